// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the tick scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pts_pkg.sv =====
// Shared constants, codes and types of the periodic tick scheduler.
package pts_pkg;

   localparam int MAX_ENTRIES_DEF  = 16;
   localparam int COUNTER_BITS_DEF = 32;

   localparam int KIND_W   = 3;
   localparam int HANDLE_W = 16;
   localparam int PERIOD_W = 16;
   localparam int STATUS_W = 3;
   localparam int REQ_DATA_W = 40;

   localparam logic [PERIOD_W-1:0] QUICK_CAP = 16'd3000;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ACTIVATE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_FIRED    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_ADDED    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_ACTSET   = 3'd6;
   localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd7;

   // Result of the shared remainder unit.
   typedef struct packed {
      logic done;
      logic zero;
   } mod_result_type;

endpackage

// ===== rtl/core/pts_mod_unit.sv =====
// Bit-serial remainder unit: tells whether the tick counter is a multiple of a period.
module pts_mod_unit #(
   parameter int COUNTER_BITS = pts_pkg::COUNTER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [COUNTER_BITS-1:0]       dividend,
   input  logic [pts_pkg::PERIOD_W-1:0]  divisor,
   output pts_pkg::mod_result_type       result
);

   localparam int STEP_W = $clog2(COUNTER_BITS + 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [COUNTER_BITS-1:0]      dvd_ff, dvd_in;
   logic [pts_pkg::PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [pts_pkg::PERIOD_W-1:0] rem_ff, rem_in;
   logic [pts_pkg::PERIOD_W:0]   trial;

   // One restoring step per cycle, most significant dividend bit first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[COUNTER_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(COUNTER_BITS);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = pts_pkg::PERIOD_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = pts_pkg::PERIOD_W'(trial);
         end
         dvd_in  = dvd_ff << 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign result.done = done_ff;
   assign result.zero = (rem_ff == '0);

endmodule

// ===== rtl/core/periodic_tick_scheduler_core.sv =====
// Top level of the periodic tick scheduler: subscriber table, sequencer and result register.
// The block keeps an ordered table of up to MAX_ENTRIES subscribers and takes one request
// transfer at a time. Add and clear finish once the result channel is free, and
// an unknown kind is dropped in the cycle that accepts it. Remove and activation walk the table
// one entry per cycle, and a remove then moves each entry behind the match down by one. A tick
// walks every entry once; each active, not pending entry with a nonzero period goes through
// the shared bit-serial remainder unit. Each fired entry and the closing tick-done result
// are shown once the result channel is free. The result register holds one finished
// transfer, so the table work goes on while the consumer stalls until the next result is
// ready to be shown.
module periodic_tick_scheduler_core #(
   parameter int MAX_ENTRIES  = pts_pkg::MAX_ENTRIES_DEF,
   parameter int COUNTER_BITS = pts_pkg::COUNTER_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pts_pkg::REQ_DATA_W-1:0]  req_tdata,  // handle, interval, immediate, enable
   input  logic [pts_pkg::KIND_W-1:0]      req_tuser,  // kind
   // Result channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pts_pkg::HANDLE_W-1:0]    rsp_tdata,  // handle_out
   output logic [pts_pkg::STATUS_W-1:0]    rsp_tuser,  // status
   output logic                            rsp_tlast,
   // Configuration register: quick mode.
   input  logic                            csr_we,
   input  logic                            csr_wdata
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int HW    = pts_pkg::HANDLE_W;
   localparam int PW    = pts_pkg::PERIOD_W;
   localparam int SW    = pts_pkg::STATUS_W;

   typedef enum logic [2:0] {
      S_IDLE, S_WALK, S_MODWAIT, S_SEARCH, S_SHIFT, S_EMIT
   } state_type;

   state_type                   state_ff, state_in, after_ff, after_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [COUNTER_BITS-1:0]     tick_ff, tick_in;
   logic                        quick_ff, quick_in;
   logic [pts_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [HW-1:0]               hdl_ff, hdl_in;
   logic                        en_ff, en_in;
   logic [HW-1:0]               handles_ff [MAX_ENTRIES];
   logic [HW-1:0]               handles_in [MAX_ENTRIES];
   logic [PW-1:0]               periods_ff [MAX_ENTRIES];
   logic [PW-1:0]               periods_in [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]      active_ff, active_in;
   logic [MAX_ENTRIES-1:0]      pending_ff, pending_in;
   logic [SW-1:0]               est_ff, est_in;
   logic [HW-1:0]               ehd_ff, ehd_in;
   logic                        els_ff, els_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]               rsp_user_ff, rsp_user_in;
   logic [HW-1:0]               rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        out_free;
   logic [IDX_W-1:0]            cur;
   logic [IDX_W-1:0]            nxt;
   logic [CNT_W:0]              idx_p1;
   logic                        mod_start;
   pts_pkg::mod_result_type     mod_res;
   logic [PW-1:0]               iv;
   logic                        emit;
   logic [SW-1:0]               emit_st;
   logic [HW-1:0]               emit_hd;
   logic                        emit_ls;
   state_type                   emit_nx;
   logic                        fire;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cur      = idx_ff[IDX_W-1:0];
   assign idx_p1   = {1'b0, idx_ff} + (CNT_W + 1)'(1);
   assign nxt      = idx_p1[IDX_W-1:0];

   pts_mod_unit #(.COUNTER_BITS(COUNTER_BITS)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (tick_ff),
      .divisor  (periods_ff[cur]),
      .result   (mod_res)
   );

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      tick_in      = tick_ff;
      quick_in     = quick_ff;
      kind_in      = kind_ff;
      hdl_in       = hdl_ff;
      en_in        = en_ff;
      handles_in   = handles_ff;
      periods_in   = periods_ff;
      active_in    = active_ff;
      pending_in   = pending_ff;
      est_in       = est_ff;
      ehd_in       = ehd_ff;
      els_in       = els_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mod_start    = 1'b0;
      emit         = 1'b0;
      emit_st      = pts_pkg::STAT_DONE;
      emit_hd      = '0;
      emit_ls      = 1'b1;
      emit_nx      = S_IDLE;
      fire         = 1'b0;

      // Quick mode caps the period of a new entry.
      iv = req_tdata[31:16];
      if (quick_ff && (iv > pts_pkg::QUICK_CAP)) begin
         iv = pts_pkg::QUICK_CAP;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_we) begin
         quick_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               hdl_in  = req_tdata[15:0];
               en_in   = req_tdata[33];
               idx_in  = '0;
               case (req_tuser)
                  pts_pkg::KIND_TICK: begin
                     tick_in  = tick_ff + COUNTER_BITS'(1);
                     state_in = S_WALK;
                  end
                  pts_pkg::KIND_ADD: begin
                     emit    = 1'b1;
                     emit_hd = req_tdata[15:0];
                     if (cnt_ff >= CNT_W'(MAX_ENTRIES)) begin
                        emit_st = pts_pkg::STAT_FULL;
                     end else begin
                        emit_st = pts_pkg::STAT_ADDED;
                        handles_in[cnt_ff[IDX_W-1:0]] = req_tdata[15:0];
                        periods_in[cnt_ff[IDX_W-1:0]] = iv;
                        active_in[cnt_ff[IDX_W-1:0]]  = 1'b1;
                        pending_in[cnt_ff[IDX_W-1:0]] = req_tdata[32];
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  pts_pkg::KIND_REMOVE, pts_pkg::KIND_ACTIVATE: begin
                     state_in = S_SEARCH;
                  end
                  pts_pkg::KIND_CLEAR: begin
                     cnt_in  = '0;
                     emit    = 1'b1;
                     emit_st = pts_pkg::STAT_CLEARED;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (idx_ff >= cnt_ff) begin
               emit = 1'b1;
            end else if (!active_ff[cur]) begin
               idx_in = idx_p1[CNT_W-1:0];
            end else if (pending_ff[cur]) begin
               fire = 1'b1;
            end else if (periods_ff[cur] == '0) begin
               idx_in = idx_p1[CNT_W-1:0];
            end else begin
               mod_start = 1'b1;
               state_in  = S_MODWAIT;
            end
         end
         S_MODWAIT: begin
            if (mod_res.done) begin
               if (mod_res.zero) begin
                  fire = 1'b1;
               end else begin
                  idx_in   = idx_p1[CNT_W-1:0];
                  state_in = S_WALK;
               end
            end
         end
         S_SEARCH: begin
            if (idx_ff >= cnt_ff) begin
               emit    = 1'b1;
               emit_st = pts_pkg::STAT_NOTFOUND;
               emit_hd = hdl_ff;
            end else if (handles_ff[cur] == hdl_ff) begin
               if (kind_ff == pts_pkg::KIND_ACTIVATE) begin
                  active_in[cur] = en_ff;
                  emit    = 1'b1;
                  emit_st = pts_pkg::STAT_ACTSET;
                  emit_hd = hdl_ff;
               end else begin
                  state_in = S_SHIFT;
               end
            end else begin
               idx_in = idx_p1[CNT_W-1:0];
            end
         end
         S_SHIFT: begin
            // Move the tail down by one entry per cycle to keep the order.
            if (idx_p1 < {1'b0, cnt_ff}) begin
               handles_in[cur] = handles_ff[nxt];
               periods_in[cur] = periods_ff[nxt];
               active_in[cur]  = active_ff[nxt];
               pending_in[cur] = pending_ff[nxt];
               idx_in = idx_p1[CNT_W-1:0];
            end else begin
               cnt_in  = cnt_ff - CNT_W'(1);
               emit    = 1'b1;
               emit_st = pts_pkg::STAT_REMOVED;
               emit_hd = hdl_ff;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = est_ff;
               rsp_data_in  = ehd_ff;
               rsp_last_in  = els_ff;
               state_in     = after_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A fired entry loses its pending mark and the walk resumes after its result.
      if (fire) begin
         pending_in[cur] = 1'b0;
         idx_in  = idx_p1[CNT_W-1:0];
         emit    = 1'b1;
         emit_st = pts_pkg::STAT_FIRED;
         emit_hd = handles_ff[cur];
         emit_ls = 1'b0;
         emit_nx = S_WALK;
      end

      if (emit) begin
         est_in   = emit_st;
         ehd_in   = emit_hd;
         els_in   = emit_ls;
         after_in = emit_nx;
         state_in = S_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         tick_ff      <= '0;
         quick_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         quick_ff     <= quick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      hdl_ff      <= hdl_in;
      en_ff       <= en_in;
      handles_ff  <= handles_in;
      periods_ff  <= periods_in;
      active_ff   <= active_in;
      pending_ff  <= pending_in;
      est_ff      <= est_in;
      ehd_ff      <= ehd_in;
      els_ff      <= els_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/pts_checker.sv =====
// Port-level checker of the periodic tick scheduler and its bind.
`include "assert_macros.svh"

module pts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [pts_pkg::KIND_W-1:0]     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pts_pkg::HANDLE_W-1:0]   rsp_tdata,
   input logic [pts_pkg::STATUS_W-1:0]   rsp_tuser,
   input logic                           rsp_tlast
);

   // A stalled result stays offered.
   `PTS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")

   // Only one known request is in work at a time; unknown kinds are dropped at once.
   `PTS_ASSERT(a_one_item, clock, reset, req_tvalid && req_tready && req_tuser <= pts_pkg::KIND_CLEAR |=> !req_tready, "request taken while busy")

   // Tick done and cleared carry a zero handle and close the run.
   `PTS_ASSERT(a_done_zero, clock, reset, rsp_tvalid && (rsp_tuser == pts_pkg::STAT_DONE || rsp_tuser == pts_pkg::STAT_CLEARED) |-> rsp_tdata == '0 && rsp_tlast, "bad closing result")

   // Nothing is offered right after reset.
   `PTS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind periodic_tick_scheduler_core pts_checker u_pts_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the periodic tick scheduler core.
`timescale 1ns / 1ps

// Scoreboard: keeps a shadow copy of the subscriber table and the queue of expected results.
class sched_scoreboard;
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] handle;
      logic        last;
   } sched_result_type;

   logic [15:0]      shadow_handle [16];
   logic [15:0]      shadow_period [16];
   bit               shadow_active [16];
   bit               shadow_pending [16];
   int               shadow_count;
   logic [31:0]      shadow_ticks;
   bit               quick;
   sched_result_type pending_results [$];
   int               error_count;

   function new();
      shadow_count = 0;
      shadow_ticks = 0;
      quick = 0;
      error_count = 0;
   endfunction

   function void push(logic [2:0] st, logic [15:0] h, logic l);
      sched_result_type r;
      r.status = st;
      r.handle = h;
      r.last = l;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function int find_handle(logic [15:0] h);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_handle[i] == h) return i;
      return -1;
   endfunction

   // Works out the results of one accepted request.
   function void note_request(logic [2:0] kind, logic [15:0] h, logic [15:0] iv,
                              bit imm, bit en);
      int idx;
      bit due;
      case (kind)
         pts_pkg::KIND_TICK: begin
            shadow_ticks = shadow_ticks + 1;
            for (int i = 0; i < shadow_count; i++) begin
               due = shadow_period[i] != 0 && (shadow_ticks % shadow_period[i]) == 0;
               if ((due || shadow_pending[i]) && shadow_active[i]) begin
                  push(pts_pkg::STAT_FIRED, shadow_handle[i], 1'b0);
                  shadow_pending[i] = 0;
               end
            end
            push(pts_pkg::STAT_DONE, 16'd0, 1'b1);
         end
         pts_pkg::KIND_ADD: begin
            if (shadow_count >= 16) begin
               push(pts_pkg::STAT_FULL, h, 1'b1);
            end else begin
               if (quick && iv > pts_pkg::QUICK_CAP) iv = pts_pkg::QUICK_CAP;
               shadow_handle[shadow_count] = h;
               shadow_period[shadow_count] = iv;
               shadow_active[shadow_count] = 1;
               shadow_pending[shadow_count] = imm;
               shadow_count++;
               push(pts_pkg::STAT_ADDED, h, 1'b1);
            end
         end
         pts_pkg::KIND_REMOVE: begin
            idx = find_handle(h);
            if (idx < 0) begin
               push(pts_pkg::STAT_NOTFOUND, h, 1'b1);
            end else begin
               for (int i = idx; i + 1 < shadow_count; i++) begin
                  shadow_handle[i] = shadow_handle[i+1];
                  shadow_period[i] = shadow_period[i+1];
                  shadow_active[i] = shadow_active[i+1];
                  shadow_pending[i] = shadow_pending[i+1];
               end
               shadow_count--;
               push(pts_pkg::STAT_REMOVED, h, 1'b1);
            end
         end
         pts_pkg::KIND_ACTIVATE: begin
            idx = find_handle(h);
            if (idx < 0) begin
               push(pts_pkg::STAT_NOTFOUND, h, 1'b1);
            end else begin
               shadow_active[idx] = en;
               push(pts_pkg::STAT_ACTSET, h, 1'b1);
            end
         end
         pts_pkg::KIND_CLEAR: begin
            shadow_count = 0;
            push(pts_pkg::STAT_CLEARED, 16'd0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Compares one accepted result with the oldest expectation.
   function void check_result(logic [2:0] st, logic [15:0] h, logic l);
      sched_result_type e;
      if (pending_results.size() == 0) begin
         $error("unexpected result: status %0d handle %0d last %0d", st, h, l);
         error_count++;
         return;
      end
      e = pending_results.pop_front();
      if (st !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, st);
         error_count++;
      end
      if (h !== e.handle) begin
         $error("handle_out: expected %0d, actual %0d", e.handle, h);
         error_count++;
      end
      if (l !== e.last) begin
         $error("last: expected %0d, actual %0d", e.last, l);
         error_count++;
      end
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // handle, interval, immediate, enable
   logic [2:0]  req_tuser = '0;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;       // handle_out
   logic [2:0]  rsp_tuser;       // status
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic        csr_wdata = 0;

   sched_scoreboard board = new();

   // Idle rates in percent; the sender side and the receiver side idle independently.
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 0;
   int  cycle_count = 0;

   // Handles recently added, reused so remove and activation usually find a match.
   logic [15:0] known_handles [$];

   always #10 clock = ~clock;

   periodic_tick_scheduler_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Receiver: checks each result transfer and picks the ready level for the next edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         rsp_tready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Watchdog on the total length of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offers one request and holds it until the transfer happens; random gaps go before it.
   // The valid level stays high after a transfer when the next request follows at once.
   task automatic send_request(logic [2:0] kind, logic [15:0] h, logic [15:0] iv,
                               bit imm, bit en);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, en, imm, iv, h};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, h, iv, imm, en);
      if (kind == pts_pkg::KIND_ADD) known_handles.insert(known_handles.size(), h);
      if (known_handles.size() > 24) void'(known_handles.pop_front());
   endtask

   // Waits until every expected result has come, then lets an unknown kind finish too.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_quick(bit value);
      drain();
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      board.quick = value;
   endtask

   function automatic logic [15:0] pick_handle();
      if (known_handles.size() != 0 && $urandom_range(3, 0) != 0)
         return known_handles[$urandom_range(known_handles.size() - 1, 0)];
      return 16'($urandom_range(65535, 0));
   endfunction

   // Random request mix: mostly adds and ticks with small periods, so entries fire often.
   task automatic random_request();
      int          sel;
      logic [15:0] iv;
      logic [15:0] h;
      logic [15:0] any_iv;
      bit          imm;
      bit          en;
      sel = $urandom_range(99, 0);
      h = 16'($urandom);
      any_iv = 16'($urandom);
      imm = 1'($urandom);
      en = 1'($urandom);
      if ($urandom_range(9, 0) == 0) iv = 16'($urandom);
      else iv = 16'($urandom_range(6, 0));
      if (sel < 40)
         send_request(pts_pkg::KIND_TICK, h, any_iv, imm, en);
      else if (sel < 65)
         send_request(pts_pkg::KIND_ADD, h, iv, imm, en);
      else if (sel < 78)
         send_request(pts_pkg::KIND_REMOVE, pick_handle(), any_iv, imm, en);
      else if (sel < 92)
         send_request(pts_pkg::KIND_ACTIVATE, pick_handle(), any_iv, imm, en);
      else if (sel < 95)
         send_request(pts_pkg::KIND_CLEAR, h, any_iv, imm, en);
      else
         send_request(3'($urandom_range(7, 5)), h, any_iv, imm, en);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: extremes, all kinds, duplicates, zero period, full table.
      write_quick(1);
      send_request(pts_pkg::KIND_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0); // capped to quick limit
      send_request(pts_pkg::KIND_ADD, 16'h0000, 16'd0, 1'b1, 1'b1);    // zero period fires once
      send_request(pts_pkg::KIND_ADD, 16'h0000, 16'd1, 1'b0, 1'b0);    // duplicate handle
      send_request(pts_pkg::KIND_ACTIVATE, 16'h0000, 16'd0, 1'b0, 1'b0); // first match off
      send_request(pts_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      send_request(pts_pkg::KIND_TICK, 16'd0, 16'd0, 1'b0, 1'b0);
      send_request(pts_pkg::KIND_ACTIVATE, 16'h0000, 16'd0, 1'b0, 1'b1);
      send_request(pts_pkg::KIND_TICK, 16'd0, 16'd0, 1'b0, 1'b0);
      send_request(pts_pkg::KIND_REMOVE, 16'h0000, 16'd0, 1'b0, 1'b0);
      send_request(pts_pkg::KIND_REMOVE, 16'h1234, 16'd0, 1'b0, 1'b0);   // missing handle
      send_request(pts_pkg::KIND_ACTIVATE, 16'h4321, 16'd0, 1'b0, 1'b1); // missing handle
      send_request(3'd5, 16'd0, 16'd0, 1'b0, 1'b0);
      send_request(3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      for (int i = 0; i < 16; i++)
         send_request(pts_pkg::KIND_ADD, 16'(i + 100), 16'(i % 3 + 1), i[0], 1'b0);
      send_request(pts_pkg::KIND_TICK, 16'd0, 16'd0, 1'b0, 1'b0);
      send_request(pts_pkg::KIND_CLEAR, 16'd0, 16'd0, 1'b0, 1'b0);
      write_quick(0);
      send_request(pts_pkg::KIND_ADD, 16'h5555, 16'hFFFF, 1'b0, 1'b0); // stays uncapped
      send_request(pts_pkg::KIND_TICK, 16'd0, 16'd0, 1'b0, 1'b0);

      // Sender pauses until every expected result has come.
      drain();

      // Receiver holds off for a long stretch while requests keep coming.
      fork
         begin
            recv_hold = 1;
            repeat (3000) @(posedge clock);
            recv_hold = 0;
         end
         for (int i = 0; i < 12; i++) random_request();
      join

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 38 : 0;
         write_quick(phase[0]);
         for (int i = 0; i < 125; i++) random_request();
      end

      drain();
      repeat (600) @(posedge clock);
      if (board.error_count == 0 && board.pending_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
